[hw/rtl/elc_pkg.sv]
// Shared types and constants for the label connectivity block.
`timescale 1ns / 1ps
package elc_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;
    localparam int LABEL_BITS_DEF = 16;

    localparam int DIM_W     = 8;
    localparam int SEG_W     = 15;
    localparam int PIX_W     = 14;
    localparam int NEW_W     = 14;
    localparam int CNT_W     = 15;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_RUN  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEGS   = 2'd2;

    typedef struct packed {
        logic acc_load;
        logic acc_read;
        logic acc_other;
        logic clr_init;
        logic clr_step;
        logic scan_rd;
        logic seed;
        logic nb_rd;
        logic nstep;
        logic nb_take;
        logic f_take;
        logic q_rd;
        logic q_take;
        logic head_inc;
        logic head_clr;
        logic relab_wr;
        logic label_inc;
        logic adv;
        logic finish;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic inb;
        logic n_last;
        logic vbit;
        logic q_last;
        logic small_region;
        logic scan_last;
    } sts_t;

endpackage

[hw/rtl/enforce_label_connectivity.sv]
// Top level: configuration registers, controller and datapath.
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | opcode, pixel_index, pixel_label
// out     | output    | out_valid / out_stall | new_label, label_count, done_res
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// Load, read and idle opcodes pass through the RESP state to a result word.
// A run clears the result memory, waits on the serial size-limit divider, then
// makes a scan visit per pixel (read and check) and a fill visit per pixel
// with its four neighbour reads, plus a relabel read and write per pixel of a
// small region and four neighbour reads per seed, all paced by the single read
// port of the result memory in the fill sequencer.
// After reset the result memory is swept before the first word is taken;
// a stalled result word holds the next.
`timescale 1ns / 1ps
module enforce_label_connectivity #(
    parameter int MAX_WIDTH  = elc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = elc_pkg::MAX_HEIGHT_DEF,
    parameter int LABEL_BITS = elc_pkg::LABEL_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      opcode,
    input  logic [elc_pkg::PIX_W-1:0]       pixel_index,
    input  logic [LABEL_BITS-1:0]           pixel_label,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [elc_pkg::NEW_W-1:0]       new_label,
    output logic [elc_pkg::CNT_W-1:0]       label_count,
    output logic                            done_res,
    input  logic                            cfg_we,
    input  logic [elc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [elc_pkg::SEG_W-1:0]       cfg_data
);
    import elc_pkg::*;

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [SEG_W-1:0] segs_reg;
    logic [WB-1:0]    w_eff;
    logic [HB-1:0]    h_eff;
    logic [SEG_W-1:0] segs_eff;
    cmd_t             cmd;
    sts_t             sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(128);
            height_reg <= DIM_W'(128);
            segs_reg   <= SEG_W'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                REG_SEGS:   segs_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WB'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = WB'(MAX_WIDTH);
        else
            w_eff = WB'(width_reg);
        if (height_reg == '0)
            h_eff = HB'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            h_eff = HB'(MAX_HEIGHT);
        else
            h_eff = HB'(height_reg);
        segs_eff = (segs_reg == '0) ? SEG_W'(1) : segs_reg;
    end

    elc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    elc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .LABEL_BITS (LABEL_BITS),
        .WB         (WB),
        .HB         (HB)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .w           (w_eff),
        .h           (h_eff),
        .segs        (segs_eff),
        .pixel_index (pixel_index),
        .pixel_label (pixel_label),
        .new_label   (new_label),
        .label_count (label_count),
        .done_res    (done_res)
    );
endmodule

[hw/rtl/elc_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module elc_div #(
    parameter int DW = 15,
    parameter int SW = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [SW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output logic          done
);
    localparam int RW = ((DW > SW) ? DW : SW) + 1;
    localparam int KW = $clog2(DW + 1);

    logic [RW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [KW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [RW-1:0] rem_sh;

    always_comb
    begin
        rem_sh = {rem_reg[RW-2:0], quo_reg[DW-1]};
        if (rem_sh >= RW'(divisor))
        begin
            rem_next = rem_sh - RW'(divisor);
            quo_next = {quo_reg[DW-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh;
            quo_next = {quo_reg[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + KW'(1);
            if (cnt_reg == KW'(DW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
endmodule

[hw/rtl/elc_datapath.sv]
// Datapath: label, result and queue memories, scan and fill registers.
`timescale 1ns / 1ps
module elc_datapath #(
    parameter int MAX_WIDTH  = elc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = elc_pkg::MAX_HEIGHT_DEF,
    parameter int LABEL_BITS = elc_pkg::LABEL_BITS_DEF,
    parameter int WB = $clog2(MAX_WIDTH + 1),
    parameter int HB = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  elc_pkg::cmd_t                 cmd,
    output elc_pkg::sts_t                 sts,
    input  logic [WB-1:0]                 w,
    input  logic [HB-1:0]                 h,
    input  logic [elc_pkg::SEG_W-1:0]     segs,
    input  logic [elc_pkg::PIX_W-1:0]     pixel_index,
    input  logic [LABEL_BITS-1:0]         pixel_label,
    output logic [elc_pkg::NEW_W-1:0]     new_label,
    output logic [elc_pkg::CNT_W-1:0]     label_count,
    output logic                          done_res
);
    import elc_pkg::*;

    localparam int PIX_MAX = MAX_WIDTH * MAX_HEIGHT;
    localparam int PB      = $clog2(PIX_MAX);
    localparam int CB      = $clog2(PIX_MAX + 1);
    localparam int CMPW    = (CB > PIX_W) ? CB : PIX_W;
    localparam int QW      = PB + WB + HB;

    logic [NEW_W:0]      out_mem [PIX_MAX];
    logic [LABEL_BITS-1:0] in_mem [PIX_MAX];
    logic [QW-1:0]       q_mem   [PIX_MAX];

    logic [NEW_W:0]        out_q;
    logic [LABEL_BITS-1:0] in_q;
    logic [QW-1:0]         q_q;

    logic [CB-1:0] clr_cnt_reg;
    logic [CB-1:0] head_reg;
    logic [CB-1:0] tail_reg;
    logic [CB-1:0] label_reg;
    logic [CB-1:0] lc_reg;
    logic          done_reg;
    logic          rdok_reg;
    logic [1:0]    n_reg;

    logic [PB-1:0] idx_reg;
    logic [WB-1:0] sx_reg;
    logic [HB-1:0] sy_reg;
    logic [PB-1:0] cidx_reg;
    logic [WB-1:0] cx_reg;
    logic [HB-1:0] cy_reg;
    logic [PB-1:0] ni_reg;
    logic [WB-1:0] nx_reg;
    logic [HB-1:0] ny_reg;
    logic [LABEL_BITS-1:0] seed_reg;
    logic [NEW_W-1:0] nbr_reg;

    logic [NEW_W-1:0] nl_reg;
    logic [CNT_W-1:0] lcout_reg;
    logic             dout_reg;

    logic [WB+HB-1:0] prod;
    logic [CB-1:0]    sz;
    logic [CB-1:0]    limit_q;
    logic             div_done;
    logic             pix_in;
    logic [PB-1:0]    pix_addr;
    logic             inb;
    logic [PB-1:0]    ni;
    logic [WB-1:0]    nx;
    logic [HB-1:0]    ny;
    logic             hit;

    logic          om_we;
    logic [PB-1:0] om_wa;
    logic [NEW_W:0] om_wd;
    logic          om_re;
    logic [PB-1:0] om_ra;
    logic [PB-1:0] im_ra;
    logic          qm_we;
    logic [PB-1:0] qm_wa;
    logic [QW-1:0] qm_wd;

    assign prod     = {{HB{1'b0}}, w} * {{WB{1'b0}}, h};
    assign sz       = CB'(prod);
    assign pix_in   = (CMPW'(pixel_index) < CMPW'(sz)) &&
                      (CMPW'(pixel_index) < CMPW'(PIX_MAX));
    assign pix_addr = PB'(pixel_index);

    elc_div #(.DW(CB), .SW(SEG_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.clr_init),
        .dividend (sz),
        .divisor  (segs),
        .quotient (limit_q),
        .done     (div_done)
    );

    always_comb
    begin
        case (n_reg)
            2'd0:
            begin
                inb = (cx_reg != '0);
                ni  = cidx_reg - PB'(1);
                nx  = cx_reg - WB'(1);
                ny  = cy_reg;
            end
            2'd1:
            begin
                inb = (cy_reg != '0);
                ni  = cidx_reg - PB'(w);
                nx  = cx_reg;
                ny  = cy_reg - HB'(1);
            end
            2'd2:
            begin
                inb = (cx_reg != w - WB'(1));
                ni  = cidx_reg + PB'(1);
                nx  = cx_reg + WB'(1);
                ny  = cy_reg;
            end
            default:
            begin
                inb = (cy_reg != h - HB'(1));
                ni  = cidx_reg + PB'(w);
                nx  = cx_reg;
                ny  = cy_reg + HB'(1);
            end
        endcase
    end

    assign hit = !out_q[NEW_W] && (in_q == seed_reg) && (tail_reg < CB'(PIX_MAX));

    always_comb
    begin
        om_we = 1'b0;
        om_wa = idx_reg;
        om_wd = {1'b1, NEW_W'(label_reg)};
        if (cmd.clr_step)
        begin
            om_we = 1'b1;
            om_wa = clr_cnt_reg[PB-1:0];
            om_wd = '0;
        end
        else if (cmd.seed)
        begin
            om_we = 1'b1;
        end
        else if (cmd.f_take && hit)
        begin
            om_we = 1'b1;
            om_wa = ni_reg;
        end
        else if (cmd.relab_wr)
        begin
            om_we = 1'b1;
            om_wa = q_q[QW-1 -: PB];
            om_wd = {1'b1, nbr_reg};
        end
        om_re = cmd.acc_read | cmd.scan_rd | cmd.nb_rd;
        om_ra = cmd.acc_read ? pix_addr : (cmd.scan_rd ? idx_reg : ni);
        im_ra = cmd.scan_rd ? idx_reg : ni;
        qm_we = cmd.seed | (cmd.f_take & hit);
        qm_wa = cmd.seed ? '0 : tail_reg[PB-1:0];
        qm_wd = cmd.seed ? {idx_reg, sx_reg, sy_reg} : {ni_reg, nx_reg, ny_reg};
    end

    always_ff @(posedge clk)
    begin
        if (om_we)
            out_mem[om_wa] <= om_wd;
        if (om_re)
            out_q <= out_mem[om_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_load && pix_in)
            in_mem[pix_addr] <= pixel_label;
        if (cmd.scan_rd || cmd.nb_rd)
            in_q <= in_mem[im_ra];
    end

    always_ff @(posedge clk)
    begin
        if (qm_we)
            q_mem[qm_wa] <= qm_wd;
        if (cmd.q_rd)
            q_q <= q_mem[head_reg[PB-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            n_reg       <= '0;
            lc_reg      <= '0;
            done_reg    <= 1'b0;
            rdok_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_init)
                clr_cnt_reg <= '0;
            else if (cmd.clr_step)
                clr_cnt_reg <= clr_cnt_reg + CB'(1);
            if (cmd.seed || cmd.head_clr)
                head_reg <= '0;
            else if (cmd.head_inc)
                head_reg <= head_reg + CB'(1);
            if (cmd.seed)
                tail_reg <= CB'(1);
            else if (cmd.f_take && hit)
                tail_reg <= tail_reg + CB'(1);
            if (cmd.seed || cmd.q_take)
                n_reg <= '0;
            else if (cmd.nstep)
                n_reg <= n_reg + 2'd1;
            if (cmd.finish)
            begin
                lc_reg   <= label_reg;
                done_reg <= 1'b1;
            end
            else if (cmd.acc_load)
                done_reg <= 1'b0;
            if (cmd.acc_read)
                rdok_reg <= pix_in;
            else if (cmd.acc_other)
                rdok_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_init)
        begin
            label_reg <= '0;
            nbr_reg   <= '0;
            idx_reg   <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
        end
        if (cmd.label_inc)
            label_reg <= label_reg + CB'(1);
        if (cmd.adv)
        begin
            idx_reg <= idx_reg + PB'(1);
            if (sx_reg == w - WB'(1))
            begin
                sx_reg <= '0;
                sy_reg <= sy_reg + HB'(1);
            end
            else
                sx_reg <= sx_reg + WB'(1);
        end
        if (cmd.seed)
        begin
            seed_reg <= in_q;
            cidx_reg <= idx_reg;
            cx_reg   <= sx_reg;
            cy_reg   <= sy_reg;
        end
        if (cmd.q_take)
        begin
            cidx_reg <= q_q[QW-1 -: PB];
            cx_reg   <= q_q[HB +: WB];
            cy_reg   <= q_q[HB-1:0];
        end
        if (cmd.nb_rd)
        begin
            ni_reg <= ni;
            nx_reg <= nx;
            ny_reg <= ny;
        end
        if (cmd.nb_take && out_q[NEW_W])
            nbr_reg <= out_q[NEW_W-1:0];
        if (cmd.out_load)
        begin
            nl_reg    <= rdok_reg && out_q[NEW_W] ? out_q[NEW_W-1:0] : '0;
            lcout_reg <= CNT_W'(lc_reg);
            dout_reg  <= done_reg;
        end
    end

    always_comb
    begin
        sts.clr_last     = (clr_cnt_reg == CB'(PIX_MAX - 1));
        sts.div_done     = div_done;
        sts.inb          = inb;
        sts.n_last       = (n_reg == 2'd3);
        sts.vbit         = out_q[NEW_W];
        sts.q_last       = (head_reg + CB'(1) == tail_reg);
        sts.small_region = (tail_reg <= (limit_q >> 2));
        sts.scan_last    = (CB'(idx_reg) == sz - CB'(1));
    end

    assign new_label   = nl_reg;
    assign label_count = lcout_reg;
    assign done_res    = dout_reg;

    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= CB'(PIX_MAX)) else $error("fill queue overrun");
    a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.q_rd |-> head_reg < tail_reg) else $error("queue read past tail");
endmodule

[hw/rtl/elc_ctrl.sv]
// Controller: item handshake, clear pass, raster scan and flood fill sequencing.
`timescale 1ns / 1ps
module elc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          opcode,
    output logic                out_valid,
    input  logic                out_stall,
    output elc_pkg::cmd_t       cmd,
    input  elc_pkg::sts_t       sts
);
    import elc_pkg::*;

    typedef enum logic [4:0] {
        S_RCLR, S_IDLE, S_RESP, S_CLR, S_DIVW, S_SC_RD, S_SC_CHK,
        S_NB_IS, S_NB_WT, S_Q_RD, S_Q_WT, S_F_IS, S_F_WT, S_F_NX,
        S_END, S_R_RD, S_R_WR, S_ADV, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_RCLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESP;
                    case (opcode)
                        OP_LOAD:
                        begin
                            cmd.acc_load  = 1'b1;
                            cmd.acc_other = 1'b1;
                        end
                        OP_READ:
                            cmd.acc_read = 1'b1;
                        OP_RUN:
                        begin
                            cmd.acc_other = 1'b1;
                            cmd.clr_init  = 1'b1;
                            state_next    = S_CLR;
                        end
                        default:
                            cmd.acc_other = 1'b1;
                    endcase
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (sts.div_done)
                    state_next = S_SC_RD;
            end
            S_SC_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SC_CHK;
            end
            S_SC_CHK:
            begin
                if (!sts.vbit)
                begin
                    cmd.seed   = 1'b1;
                    state_next = S_NB_IS;
                end
                else if (sts.scan_last)
                    state_next = S_FIN;
                else
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_SC_RD;
                end
            end
            S_NB_IS:
            begin
                if (sts.inb)
                begin
                    cmd.nb_rd  = 1'b1;
                    state_next = S_NB_WT;
                end
                else
                begin
                    cmd.nstep  = 1'b1;
                    state_next = sts.n_last ? S_Q_RD : S_NB_IS;
                end
            end
            S_NB_WT:
            begin
                cmd.nb_take = 1'b1;
                cmd.nstep   = 1'b1;
                state_next  = sts.n_last ? S_Q_RD : S_NB_IS;
            end
            S_Q_RD:
            begin
                cmd.q_rd   = 1'b1;
                state_next = S_Q_WT;
            end
            S_Q_WT:
            begin
                cmd.q_take = 1'b1;
                state_next = S_F_IS;
            end
            S_F_IS:
            begin
                if (sts.inb)
                begin
                    cmd.nb_rd  = 1'b1;
                    state_next = S_F_WT;
                end
                else
                begin
                    cmd.nstep  = 1'b1;
                    state_next = sts.n_last ? S_F_NX : S_F_IS;
                end
            end
            S_F_WT:
            begin
                cmd.f_take = 1'b1;
                cmd.nstep  = 1'b1;
                state_next = sts.n_last ? S_F_NX : S_F_IS;
            end
            S_F_NX:
            begin
                cmd.head_inc = 1'b1;
                state_next   = sts.q_last ? S_END : S_Q_RD;
            end
            S_END:
            begin
                if (sts.small_region)
                begin
                    cmd.head_clr = 1'b1;
                    state_next   = S_R_RD;
                end
                else
                begin
                    cmd.label_inc = 1'b1;
                    state_next    = S_ADV;
                end
            end
            S_R_RD:
            begin
                cmd.q_rd   = 1'b1;
                state_next = S_R_WR;
            end
            S_R_WR:
            begin
                cmd.relab_wr = 1'b1;
                cmd.head_inc = 1'b1;
                state_next   = sts.q_last ? S_ADV : S_R_RD;
            end
            S_ADV:
            begin
                if (sts.scan_last)
                    state_next = S_FIN;
                else
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_SC_RD;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_RESP;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RCLR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE) else $error("accept left block idle");
    a_resp_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && (!out_valid_reg || !out_stall)) |=> out_valid_reg)
        else $error("result word not presented");
    a_seed_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SC_CHK && !sts.vbit) |=> state_reg == S_NB_IS)
        else $error("seed did not start neighbour check");
endmodule
